### src/vit_pkg.sv
// types, constants and the pattern table of the velthuis / iast transliterator
// used by every module of the block; depends on nothing
package vit_pkg;

  // longest pattern or replacement in bytes
  localparam int unsigned PatMax   = 3;
  localparam int unsigned TableLen = 41;

  // token queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // direction register codes
  localparam logic DirToIast     = 1'b0;
  localparam logic DirToVelthuis = 1'b1;

  // one table entry, first byte in the top bits of each 24-bit field
  typedef struct packed {
    logic [1:0]  vel_len;
    logic [23:0] vel;
    logic [1:0]  iast_len;
    logic [23:0] iast;
  } pair_t;

  // outcome of one match decision
  typedef struct packed {
    logic [23:0] rep;
    logic [1:0]  rep_len;
    logic [1:0]  pat_len;
  } match_t;

  // request handed from front to back: a replacement of one to three bytes
  typedef struct packed {
    logic [23:0] rep;
    logic [1:0]  rep_len;
    logic        last;
  } token_t;

  localparam pair_t Pairs [TableLen] = '{
    '{2'd2, 24'h416100, 2'd2, 24'hC48000},  // Aa
    '{2'd2, 24'h496900, 2'd2, 24'hC4AA00},  // Ii
    '{2'd2, 24'h557500, 2'd2, 24'hC5AA00},  // Uu
    '{2'd3, 24'h2E5272, 2'd3, 24'hE1B99C},  // .Rr
    '{2'd3, 24'h2E4C6C, 2'd3, 24'hE1B8B8},  // .Ll
    '{2'd2, 24'h616100, 2'd2, 24'hC48100},  // aa
    '{2'd2, 24'h414100, 2'd2, 24'hC48000},  // AA
    '{2'd2, 24'h696900, 2'd2, 24'hC4AB00},  // ii
    '{2'd2, 24'h494900, 2'd2, 24'hC4AA00},  // II
    '{2'd2, 24'h757500, 2'd2, 24'hC5AB00},  // uu
    '{2'd2, 24'h555500, 2'd2, 24'hC5AA00},  // UU
    '{2'd3, 24'h2E7272, 2'd3, 24'hE1B99D},  // .rr
    '{2'd3, 24'h2E5252, 2'd3, 24'hE1B99C},  // .RR
    '{2'd2, 24'h2E7200, 2'd3, 24'hE1B99B},  // .r
    '{2'd2, 24'h2E5200, 2'd3, 24'hE1B99A},  // .R
    '{2'd3, 24'h2E6C6C, 2'd3, 24'hE1B8B9},  // .ll
    '{2'd3, 24'h2E4C4C, 2'd3, 24'hE1B8B8},  // .LL
    '{2'd2, 24'h2E6C00, 2'd3, 24'hE1B8B7},  // .l
    '{2'd2, 24'h2E4C00, 2'd3, 24'hE1B8B6},  // .L
    '{2'd2, 24'h2E6D00, 2'd3, 24'hE1B983},  // .m
    '{2'd2, 24'h2E4D00, 2'd3, 24'hE1B982},  // .M
    '{2'd2, 24'h2E6800, 2'd3, 24'hE1B8A5},  // .h
    '{2'd2, 24'h2E4800, 2'd3, 24'hE1B8A4},  // .H
    '{2'd2, 24'h226E00, 2'd3, 24'hE1B985},  // "n
    '{2'd2, 24'h224E00, 2'd3, 24'hE1B984},  // "N
    '{2'd2, 24'h7E6E00, 2'd2, 24'hC3B100},  // ~n
    '{2'd2, 24'h7E4E00, 2'd2, 24'hC39100},  // ~N
    '{2'd2, 24'h227300, 2'd2, 24'hC59B00},  // "s
    '{2'd2, 24'h225300, 2'd2, 24'hC59A00},  // "S
    '{2'd2, 24'h2E7400, 2'd3, 24'hE1B9AD},  // .t
    '{2'd2, 24'h2E5400, 2'd3, 24'hE1B9AC},  // .T
    '{2'd2, 24'h2E6400, 2'd3, 24'hE1B88D},  // .d
    '{2'd2, 24'h2E4400, 2'd3, 24'hE1B88C},  // .D
    '{2'd2, 24'h2E6E00, 2'd3, 24'hE1B987},  // .n
    '{2'd2, 24'h2E4E00, 2'd3, 24'hE1B986},  // .N
    '{2'd2, 24'h2E7300, 2'd3, 24'hE1B9A3},  // .s
    '{2'd2, 24'h2E5300, 2'd3, 24'hE1B9A2},  // .S
    '{2'd1, 24'h2F0000, 2'd3, 24'h6DCC90},  // slash, candrabindu
    '{2'd2, 24'h2E6100, 2'd1, 24'h270000},  // .a, avagraha
    '{2'd1, 24'h5F0000, 2'd3, 24'hE2808C},  // underscore, zero width non-joiner
    '{2'd1, 24'h2B0000, 2'd3, 24'hE2808D}   // plus, zero width joiner
  };

  // first table entry whose pattern is a prefix of the valid window bytes wins;
  // without a hit the front byte passes through
  function automatic match_t pat_match(logic dir, logic [23:0] win, logic [1:0] cnt);
    pair_t       p;
    logic [23:0] pat;
    logic [23:0] rep;
    logic [1:0]  plen;
    logic [1:0]  rlen;
    logic        hit;
    match_t      res;
    res.rep     = {win[23:16], 16'h0000};
    res.rep_len = 2'd1;
    res.pat_len = 2'd1;
    // scan from the end so the lowest index overrides
    for (int i = TableLen - 1; i >= 0; i--) begin
      p    = Pairs[i];
      pat  = (dir == DirToVelthuis) ? p.iast : p.vel;
      plen = (dir == DirToVelthuis) ? p.iast_len : p.vel_len;
      rep  = (dir == DirToVelthuis) ? p.vel : p.iast;
      rlen = (dir == DirToVelthuis) ? p.vel_len : p.iast_len;
      hit  = (plen <= cnt) && (win[23:16] == pat[23:16]) &&
             ((plen < 2'd2) || (win[15:8] == pat[15:8])) &&
             ((plen < 2'd3) || (win[7:0] == pat[7:0]));
      if (hit) begin
        res.rep     = rep;
        res.rep_len = rlen;
        res.pat_len = plen;
      end
    end
    return res;
  endfunction

endpackage

### src/vit_front.sv
// front part: takes input bytes into the three-byte window until a match
// decision is due, then pushes a replacement request; depends on vit_pkg
module vit_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            dir_i,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  logic [7:0]      s_axis_tdata_i,   // in_byte
  input  logic            s_axis_tlast_i,   // end_of_text
  output logic            tok_valid_o,
  input  logic            tok_ready_i,
  output vit_pkg::token_t tok_o
);

  logic [7:0]       win_q [vit_pkg::PatMax];
  logic [1:0]       count_q, count_d;
  logic             flush_q, flush_d;
  logic             need_dec;
  logic             dec_fire;
  logic             in_fire;
  vit_pkg::match_t  m;

  // a decision is due on a full window or while flushing the tail
  assign need_dec        = (count_q == 2'd3) || (flush_q && (count_q != 2'd0));
  assign dec_fire        = need_dec && tok_ready_i;
  assign s_axis_tready_o = !need_dec;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // table match on the current window
  assign m = vit_pkg::pat_match(dir_i, {win_q[0], win_q[1], win_q[2]}, count_q);

  // request toward the back
  always_comb begin
    tok_valid_o  = need_dec;
    tok_o.rep     = m.rep;
    tok_o.rep_len = m.rep_len;
    tok_o.last    = flush_q && (m.pat_len >= count_q);
  end

  // window fill level and flush flag
  always_comb begin
    count_d = count_q;
    flush_d = flush_q;
    if (in_fire) begin
      count_d = count_q + 2'd1;
      flush_d = s_axis_tlast_i;
    end else if (dec_fire) begin
      if (m.pat_len >= count_q) begin
        count_d = 2'd0;
        flush_d = 1'b0;
      end else begin
        count_d = count_q - m.pat_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      flush_q <= 1'b0;
    end else begin
      count_q <= count_d;
      flush_q <= flush_d;
    end
  end

  // window bytes: append at the fill level, shift out consumed bytes
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      win_q[count_q] <= s_axis_tdata_i;
    end else if (dec_fire) begin
      if (m.pat_len == 2'd1) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
      end else begin
        win_q[0] <= win_q[2];
      end
    end
  end

endmodule

### src/vit_queue.sv
// short request queue between front and back, so each side stalls on its own
// depends on vit_pkg
module vit_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  vit_pkg::token_t push_tok_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output vit_pkg::token_t pop_tok_o
);

  localparam int unsigned PtrW = vit_pkg::QueuePtrW;

  vit_pkg::token_t mem_q [vit_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (cnt_q != (PtrW + 1)'(vit_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_tok_o    = mem_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

### src/vit_back.sv
// back part: splits each replacement request into bytes, one per cycle while
// the output is not stalled, into the output register; depends on vit_pkg
module vit_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tok_valid_i,
  input  vit_pkg::token_t tok_i,
  output logic            pop_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // out_byte
  output logic            m_axis_tlast_o    // last
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q;
  logic       out_last_q;
  logic       adv;
  logic       at_end;
  logic [7:0] sel_byte;

  assign adv    = !out_valid_q || m_axis_tready_i;
  assign at_end = (idx_q == (tok_i.rep_len - 2'd1));
  assign pop_o  = adv && tok_valid_i && at_end;

  // byte of the head request at the current position
  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = tok_i.rep[23:16];
      2'd1:    sel_byte = tok_i.rep[15:8];
      2'd2:    sel_byte = tok_i.rep[7:0];
      default: sel_byte = tok_i.rep[23:16];
    endcase
  end

  // position and output valid
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = tok_valid_i;
      if (tok_valid_i) begin
        idx_d = at_end ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (adv && tok_valid_i) begin
      out_data_q <= sel_byte;
      out_last_q <= tok_i.last && at_end;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

### src/velthuis_iast_transliterator.sv
// velthuis / iast transliterator top level: front, request queue, back
// path of a byte: window register, request queue, output register
// throughput: one output byte per cycle at the output register unless it stalls; the
// front takes no input byte while a match decision is due
// reset: asynchronous, active low; clears window fill level, queue, output and direction
// depends on vit_pkg, vit_front, vit_queue, vit_back
module velthuis_iast_transliterator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,      // direction
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // in_byte
  input  logic       s_axis_tlast_i,   // end_of_text
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // out_byte
  output logic       m_axis_tlast_o    // last
);

  logic            dir_q;
  logic            fq_valid, fq_ready;
  vit_pkg::token_t fq_tok;
  logic            qb_valid, qb_pop;
  vit_pkg::token_t qb_tok;

  // direction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= vit_pkg::DirToIast;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  vit_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dir_i           (dir_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .tok_valid_o     (fq_valid),
    .tok_ready_i     (fq_ready),
    .tok_o           (fq_tok)
  );

  vit_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_tok_i   (fq_tok),
    .pop_valid_o  (qb_valid),
    .pop_i        (qb_pop),
    .pop_tok_o    (qb_tok)
  );

  vit_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tok_valid_i     (qb_valid),
    .tok_i           (qb_tok),
    .pop_o           (qb_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
